/* hw/rtl/itp_pkg.sv */
package itp_pkg;

  localparam int FRACTION_DIGITS_MAX = 18;

  // largest power of ten that the fraction count may reach, minus one
  function automatic logic [63:0] pow10_minus1(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p - 64'd1;
  endfunction

  localparam logic [63:0] FRAC_LIMIT = pow10_minus1(FRACTION_DIGITS_MAX);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5a;

  localparam logic [2:0] YEAR_DIGITS    = 3'd4;
  localparam logic [2:0] FIELD_DIGITS   = 3'd2;
  localparam logic [2:0] ZONE_COLON_POS = 3'd2;
  localparam logic [2:0] ZONE_CHARS     = 3'd5;

  localparam logic [15:0] SECS_PER_MIN  = 16'd60;
  localparam logic [15:0] SECS_PER_HOUR = 16'd3600;

  typedef enum logic [3:0] {
    PH_YEAR, PH_SEP1, PH_MONTH, PH_SEP2, PH_DAY, PH_SEPT, PH_HOUR, PH_COL1,
    PH_MIN, PH_COL2, PH_SEC, PH_AFTER_SEC, PH_FRAC, PH_ZONE, PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  digit_cnt;
    logic [13:0] field_acc;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [59:0] frac_acc;
    logic [18:0] zone_mag;
    logic        zone_neg;
    logic        err;
    logic        has_frac;
    logic        utc;
  } itp_state_t;

  localparam itp_state_t ST_RESET = '{phase: PH_YEAR, default: '0};

  typedef struct packed {
    logic               valid_res;
    logic [13:0]        year;
    logic [6:0]         month;
    logic [6:0]         day;
    logic [6:0]         hour;
    logic [6:0]         minute;
    logic [6:0]         second;
    logic               has_fraction;
    logic [59:0]        fraction_value;
    logic               utc_form;
    logic signed [19:0] offset_seconds;
  } itp_result_t;

endpackage

/* hw/rtl/itp_char_step.sv */
module itp_char_step (
  input  itp_pkg::itp_state_t cur,
  input  logic [7:0]          char_in,
  output itp_pkg::itp_state_t nxt
);

  logic        is_digit;
  logic [3:0]  dval;
  logic [2:0]  cnt_inc;
  logic        field_done;
  logic [17:0] field_mul;
  logic [13:0] field_val;
  logic [63:0] frac_mul;
  logic [59:0] frac_val;
  logic [15:0] zone_w;
  logic [19:0] zone_prod;

  // zone designator right after the seconds or the fraction
  function automatic itp_pkg::itp_state_t zone_char(input itp_pkg::itp_state_t s,
                                                    input logic [7:0] c);
    itp_pkg::itp_state_t r;
    r = s;
    if (c == itp_pkg::CH_Z) begin
      r.utc   = 1'b1;
      r.phase = itp_pkg::PH_DONE;
    end else if (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_DASH) begin
      r.zone_neg  = (c == itp_pkg::CH_DASH);
      r.digit_cnt = '0;
      r.phase     = itp_pkg::PH_ZONE;
    end else begin
      r.phase = itp_pkg::PH_DONE;
    end
    return r;
  endfunction

  assign is_digit = (char_in >= itp_pkg::CH_ZERO) && (char_in <= itp_pkg::CH_NINE);
  assign dval     = char_in[3:0];
  assign cnt_inc  = cur.digit_cnt + 3'd1;

  // times ten as two shifts
  assign field_mul = {1'b0, cur.field_acc, 3'b000} + {3'b000, cur.field_acc, 1'b0}
                   + {14'd0, dval};
  assign field_val = field_mul[13:0];
  assign field_done = (cur.phase == itp_pkg::PH_YEAR) ? (cnt_inc >= itp_pkg::YEAR_DIGITS)
                                                      : (cnt_inc >= itp_pkg::FIELD_DIGITS);

  assign frac_mul = {1'b0, cur.frac_acc, 3'b000} + {3'b000, cur.frac_acc, 1'b0}
                  + {60'd0, dval};
  assign frac_val = (frac_mul > itp_pkg::FRAC_LIMIT) ? itp_pkg::FRAC_LIMIT[59:0]
                                                     : frac_mul[59:0];

  // each zone digit adds its weight in seconds
  always_comb begin
    case (cur.digit_cnt)
      3'd0:    zone_w = 16'(itp_pkg::SECS_PER_HOUR * 16'd10);
      3'd1:    zone_w = itp_pkg::SECS_PER_HOUR;
      3'd3:    zone_w = 16'(itp_pkg::SECS_PER_MIN * 16'd10);
      3'd4:    zone_w = itp_pkg::SECS_PER_MIN;
      default: zone_w = 16'd0;
    endcase
  end

  assign zone_prod = {4'd0, zone_w} * {16'd0, dval};

  always_comb begin
    nxt = cur;
    if (!cur.err) begin
      unique case (cur.phase) inside
        itp_pkg::PH_YEAR, itp_pkg::PH_MONTH, itp_pkg::PH_DAY,
        itp_pkg::PH_HOUR, itp_pkg::PH_MIN, itp_pkg::PH_SEC: begin
          if (!is_digit) begin
            nxt.err = 1'b1;
          end else if (field_done) begin
            nxt.field_acc = '0;
            nxt.digit_cnt = '0;
            nxt.phase     = itp_pkg::phase_t'(cur.phase + 4'd1);
            case (cur.phase)
              itp_pkg::PH_YEAR:  nxt.year   = field_val;
              itp_pkg::PH_MONTH: nxt.month  = field_val[6:0];
              itp_pkg::PH_DAY:   nxt.day    = field_val[6:0];
              itp_pkg::PH_HOUR:  nxt.hour   = field_val[6:0];
              itp_pkg::PH_MIN:   nxt.minute = field_val[6:0];
              default:           nxt.second = field_val[6:0];
            endcase
          end else begin
            nxt.field_acc = field_val;
            nxt.digit_cnt = cnt_inc;
          end
        end
        itp_pkg::PH_SEP1, itp_pkg::PH_SEP2: begin
          if (char_in == itp_pkg::CH_DASH) nxt.phase = itp_pkg::phase_t'(cur.phase + 4'd1);
          else nxt.err = 1'b1;
        end
        itp_pkg::PH_SEPT: begin
          if (char_in == itp_pkg::CH_T) nxt.phase = itp_pkg::PH_HOUR;
          else nxt.err = 1'b1;
        end
        itp_pkg::PH_COL1, itp_pkg::PH_COL2: begin
          if (char_in == itp_pkg::CH_COLON) nxt.phase = itp_pkg::phase_t'(cur.phase + 4'd1);
          else nxt.err = 1'b1;
        end
        itp_pkg::PH_AFTER_SEC: begin
          if (char_in == itp_pkg::CH_DOT) begin
            nxt.has_frac = 1'b1;
            nxt.phase    = itp_pkg::PH_FRAC;
          end else begin
            nxt = zone_char(cur, char_in);
          end
        end
        itp_pkg::PH_FRAC: begin
          if (is_digit) nxt.frac_acc = frac_val;
          else nxt = zone_char(cur, char_in);
        end
        itp_pkg::PH_ZONE: begin
          if (cur.digit_cnt == itp_pkg::ZONE_COLON_POS) begin
            if (char_in != itp_pkg::CH_COLON) nxt.err = 1'b1;
          end else if (!is_digit) begin
            nxt.err = 1'b1;
          end else begin
            nxt.zone_mag = cur.zone_mag + zone_prod[18:0];
          end
          if (!nxt.err) begin
            nxt.digit_cnt = cnt_inc;
            if (cnt_inc >= itp_pkg::ZONE_CHARS) nxt.phase = itp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/iso8601_timestamp_parser.sv */
// Streaming ISO 8601 timestamp parser: one byte of text per request on the input
// channel, with in_last_char set on the final byte; that byte produces exactly one
// result (date and time fields, fraction digits as an integer saturating at 18 digits,
// zone offset in seconds) and returns the parser to its start state for the next
// string. A byte can be accepted in every clock cycle; only the last byte of a string
// waits in the input stage, and holds off further bytes, while the previous result is
// still stalled by out_ready. The result is registered as its last byte leaves the input
// stage, which happens as soon as the result register is free.
// The longest path is the fraction accumulator: a 64-bit multiply-by-ten add and the
// saturation compare, done once per byte.
module iso8601_timestamp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_in,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic [13:0]        out_year,
  output logic [6:0]         out_month,
  output logic [6:0]         out_day,
  output logic [6:0]         out_hour,
  output logic [6:0]         out_minute,
  output logic [6:0]         out_second,
  output logic               out_has_fraction,
  output logic [59:0]        out_fraction_value,
  output logic               out_utc_form,
  output logic signed [19:0] out_offset_seconds
);

  logic                 s1_valid_r;
  logic [7:0]           s1_char_r;
  logic                 s1_last_r;
  itp_pkg::itp_state_t  st_r;
  itp_pkg::itp_state_t  st_nxt;
  logic                 out_valid_r;
  itp_pkg::itp_result_t res_r;
  itp_pkg::itp_result_t res_nxt;
  logic                 out_free;
  logic                 s1_adv;
  logic                 res_ok;
  logic [19:0]          off_mag;

  itp_char_step u_step (
    .cur     (st_r),
    .char_in (s1_char_r),
    .nxt     (st_nxt)
  );

  // a last byte waits in the input stage until the result register is free
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  assign res_ok  = !st_nxt.err && (st_nxt.phase == itp_pkg::PH_AFTER_SEC ||
                                   st_nxt.phase == itp_pkg::PH_FRAC ||
                                   st_nxt.phase == itp_pkg::PH_DONE);
  assign off_mag = {1'b0, st_nxt.zone_mag};

  always_comb begin
    res_nxt = '0;
    if (res_ok) begin
      res_nxt.valid_res      = 1'b1;
      res_nxt.year           = st_nxt.year;
      res_nxt.month          = st_nxt.month;
      res_nxt.day            = st_nxt.day;
      res_nxt.hour           = st_nxt.hour;
      res_nxt.minute         = st_nxt.minute;
      res_nxt.second         = st_nxt.second;
      res_nxt.has_fraction   = st_nxt.has_frac;
      res_nxt.fraction_value = st_nxt.frac_acc;
      res_nxt.utc_form       = st_nxt.utc;
      res_nxt.offset_seconds = st_nxt.zone_neg ? (20'd0 - off_mag) : off_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= itp_pkg::ST_RESET;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_adv) st_r <= s1_last_r ? itp_pkg::ST_RESET : st_nxt;
      if (s1_adv && s1_last_r) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_last_char;
    end
    if (s1_adv && s1_last_r) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_valid_res      = res_r.valid_res;
  assign out_year           = res_r.year;
  assign out_month          = res_r.month;
  assign out_day            = res_r.day;
  assign out_hour           = res_r.hour;
  assign out_minute         = res_r.minute;
  assign out_second         = res_r.second;
  assign out_has_fraction   = res_r.has_fraction;
  assign out_fraction_value = res_r.fraction_value;
  assign out_utc_form       = res_r.utc_form;
  assign out_offset_seconds = res_r.offset_seconds;

endmodule

/* hw/rtl/itp_checker.sv */
module itp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_valid_res,
  input logic [13:0]        out_year,
  input logic [6:0]         out_month,
  input logic [6:0]         out_day,
  input logic [6:0]         out_hour,
  input logic [6:0]         out_minute,
  input logic [6:0]         out_second,
  input logic               out_has_fraction,
  input logic [59:0]        out_fraction_value,
  input logic               out_utc_form,
  input logic signed [19:0] out_offset_seconds
);

  // a stalled result holds its valid flag, year, second, fraction and offset
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res) && $stable(out_year)
      && $stable(out_second) && $stable(out_fraction_value)
      && $stable(out_offset_seconds))
    else $error("result changed while stalled");

  // a format error clears every field
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_year == 14'd0 && out_month == 7'd0
      && out_day == 7'd0 && out_hour == 7'd0 && out_minute == 7'd0
      && out_second == 7'd0 && !out_has_fraction && out_fraction_value == 60'd0
      && !out_utc_form && out_offset_seconds == 20'sd0)
    else $error("invalid result carries nonzero fields");

  a_utc_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_utc_form |-> out_offset_seconds == 20'sd0)
    else $error("utc form with nonzero offset");

  a_no_fraction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_fraction |-> out_fraction_value == 60'd0)
    else $error("fraction value without decimal point");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind iso8601_timestamp_parser itp_checker u_itp_checker (.*);
